[src/lss_pkg.sv]
// ---------------------------------------------------------------------------
// lss_pkg
// Shared widths, register codes, reset values and angle bounds of the lidar
// sector steering block.
// ---------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int DIST_W  = 16;
  localparam int CNT_W   = 10;
  localparam int SPEED_W = 8;
  localparam int TURN_W  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DISTANCE  = 3'd0,
    REG_RADIUS        = 3'd1,
    REG_FAR_DISTANCE  = 3'd2,
    REG_DEADBAND      = 3'd3,
    REG_STEER_GAIN    = 3'd4,
    REG_FORWARD_SPEED = 3'd5,
    REG_BACK_LIMIT    = 3'd6,
    REG_FAR_MIN       = 3'd7
  } lss_reg_t;

  // register reset values
  localparam logic [DIST_W-1:0]  RST_MIN_DISTANCE  = 16'd50;
  localparam logic [DIST_W-1:0]  RST_RADIUS        = 16'd800;
  localparam logic [DIST_W-1:0]  RST_FAR_DISTANCE  = 16'd3000;
  localparam logic [CNT_W-1:0]   RST_DEADBAND      = 10'd8;
  localparam logic [CNT_W-1:0]   RST_STEER_GAIN    = 10'd50;
  localparam logic [SPEED_W-1:0] RST_FORWARD_SPEED = 8'd4;
  localparam logic [CNT_W-1:0]   RST_BACK_LIMIT    = 10'd11;
  localparam logic [CNT_W-1:0]   RST_FAR_MIN       = 10'd5;

  // bearing bounds in hundredths of a degree
  localparam logic signed [ANGLE_W-1:0] ANGLE_ZERO    = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = 16'sd9000;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF    = 16'sd18000;

  // turn command magnitude limit
  localparam logic [TURN_W-1:0] TURN_LIMIT = 20'd512000;

  // per-scan sector counts
  typedef struct packed {
    logic [CNT_W-1:0] front_right;
    logic [CNT_W-1:0] front_left;
    logic [CNT_W-1:0] back_left;
    logic [CNT_W-1:0] back_right;
    logic [CNT_W-1:0] far;
  } lss_counts_t;

endpackage

`default_nettype wire

[src/lss_in_if.sv]
// ---------------------------------------------------------------------------
// lss_in_if
// Point channel: one lidar point per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface lss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lss_pkg::ANGLE_W-1:0]  angle_cdeg;
  logic        [lss_pkg::DIST_W-1:0]   distance_mm;
  logic                                last_point;

  modport source (output valid, output angle_cdeg, output distance_mm,
                  output last_point, input ready);
  modport sink   (input valid, input angle_cdeg, input distance_mm,
                  input last_point, output ready);
endinterface

`default_nettype wire

[src/lss_out_if.sv]
// ---------------------------------------------------------------------------
// lss_out_if
// Result channel: sector counts and steering command, one request per scan.
// ---------------------------------------------------------------------------
`default_nettype none

interface lss_out_if;
  logic                               valid;
  logic                               ready;
  logic        [lss_pkg::CNT_W-1:0]   front_right_count;
  logic        [lss_pkg::CNT_W-1:0]   front_left_count;
  logic        [lss_pkg::CNT_W-1:0]   back_left_count;
  logic        [lss_pkg::CNT_W-1:0]   back_right_count;
  logic        [lss_pkg::CNT_W-1:0]   far_count;
  logic        [lss_pkg::SPEED_W-1:0] speed_cmd;
  logic signed [lss_pkg::TURN_W-1:0]  turn_rate_milli;
  logic                               zone;

  modport source (output valid, output front_right_count, output front_left_count,
                  output back_left_count, output back_right_count, output far_count,
                  output speed_cmd, output turn_rate_milli, output zone,
                  input ready);
  modport sink   (input valid, input front_right_count, input front_left_count,
                  input back_left_count, input back_right_count, input far_count,
                  input speed_cmd, input turn_rate_milli, input zone,
                  output ready);
endinterface

`default_nettype wire

[src/lss_cfg_if.sv]
// ---------------------------------------------------------------------------
// lss_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface lss_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lss_pkg::CFG_IDX_W-1:0]      index;
  logic [lss_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/lidar_sector_steering_core.sv]
// ---------------------------------------------------------------------------
// lidar_sector_steering_core
// Sorts the lidar points of a scan into sectors and issues a speed and
// turn command with the sector counts at the end of each scan.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one lidar point per request (bearing, range, last_point flag).
//   out_ch : one result request per scan, issued for the point that carries
//            last_point; other points give no result.
//   cfg_ch : register writes, always ready; write only while the block idles.
// Throughput: one point per cycle while in_ch.ready is high. Points run
//   through an input register, the sector counters and a scan snapshot
//   register, then the output register where the turn product is formed.
// Result path: once the last point of a scan is accepted, its counts pass
//   through the scan snapshot register into the output register.
// Stalls: the output register holds a finished result until taken; the
//   snapshot register holds the next one, and points keep flowing into the
//   counters until a further last_point reaches the input register while
//   both hold a result, at which point in_ch.ready drops.
// Reset: registers take their default values, counters and the zone flag
//   clear, all stages empty.
// ---------------------------------------------------------------------------
`default_nettype none

module lidar_sector_steering_core #(
  parameter int MAX_POINTS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  lss_in_if.sink      in_ch,
  lss_out_if.source   out_ch,
  lss_cfg_if.sink     cfg_ch
);

  localparam int CW      = lss_pkg::CNT_W;
  localparam int TW      = lss_pkg::TURN_W;
  localparam int CAP_INT = (MAX_POINTS < 1023) ? MAX_POINTS : 1023;
  localparam logic [CW-1:0] CNT_CAP = CW'(CAP_INT);

  // configuration registers
  logic [lss_pkg::DIST_W-1:0]  min_dist_r, radius_r, far_dist_r;
  logic [CW-1:0]               deadband_r, gain_r, back_limit_r, far_min_r;
  logic [lss_pkg::SPEED_W-1:0] speed_r;

  // input stage
  logic                                a_valid_r;
  logic signed [lss_pkg::ANGLE_W-1:0]  a_angle_r;
  logic        [lss_pkg::DIST_W-1:0]   a_dist_r;
  logic                                a_last_r;

  // counters and scan snapshot
  lss_pkg::lss_counts_t cnt_r, cnt_nxt, cnt_bump;
  lss_pkg::lss_counts_t b_cnt_r;
  logic                 b_valid_r, b_valid_nxt;

  // output stage
  logic                  out_valid_r, out_valid_nxt;
  lss_pkg::lss_counts_t  out_cnt_r;
  logic [lss_pkg::SPEED_W-1:0] out_speed_r;
  logic signed [TW-1:0]  out_turn_r, turn_nxt;
  logic                  out_zone_r, zone_r, zone_nxt;

  // flow control
  logic a_adv, b_adv, b_free;

  // classification
  logic near_band, ang_fr, ang_fl, ang_bl, ang_br, ang_fwd;
  logic hit_fr, hit_fl, hit_bl, hit_br, hit_far;

  // steering math
  logic [CW-1:0]   abs_diff, excess;
  logic            turning, turn_left_high;
  logic [TW-1:0]   prod, prod_sat;
  logic            zone_cond;

  // handshake chain from the output register back to the input
  assign b_adv  = b_valid_r && (!out_valid_r || out_ch.ready);
  assign b_free = !b_valid_r || b_adv;
  assign a_adv  = a_valid_r && (!a_last_r || b_free);
  assign in_ch.ready  = !a_valid_r || a_adv;
  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r   <= lss_pkg::RST_MIN_DISTANCE;
      radius_r     <= lss_pkg::RST_RADIUS;
      far_dist_r   <= lss_pkg::RST_FAR_DISTANCE;
      deadband_r   <= lss_pkg::RST_DEADBAND;
      gain_r       <= lss_pkg::RST_STEER_GAIN;
      speed_r      <= lss_pkg::RST_FORWARD_SPEED;
      back_limit_r <= lss_pkg::RST_BACK_LIMIT;
      far_min_r    <= lss_pkg::RST_FAR_MIN;
    end else if (cfg_ch.valid) begin
      case (lss_pkg::lss_reg_t'(cfg_ch.index))
        lss_pkg::REG_MIN_DISTANCE:  min_dist_r   <= cfg_ch.data;
        lss_pkg::REG_RADIUS:        radius_r     <= cfg_ch.data;
        lss_pkg::REG_FAR_DISTANCE:  far_dist_r   <= cfg_ch.data;
        lss_pkg::REG_DEADBAND:      deadband_r   <= cfg_ch.data[CW-1:0];
        lss_pkg::REG_STEER_GAIN:    gain_r       <= cfg_ch.data[CW-1:0];
        lss_pkg::REG_FORWARD_SPEED: speed_r      <= cfg_ch.data[lss_pkg::SPEED_W-1:0];
        lss_pkg::REG_BACK_LIMIT:    back_limit_r <= cfg_ch.data[CW-1:0];
        lss_pkg::REG_FAR_MIN:       far_min_r    <= cfg_ch.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_angle_r <= in_ch.angle_cdeg;
      a_dist_r  <= in_ch.distance_mm;
      a_last_r  <= in_ch.last_point;
    end
  end

  // sector tests, strict bounds, first match wins
  always_comb begin
    near_band = (min_dist_r < a_dist_r) && (a_dist_r < radius_r);
    ang_fr  = (a_angle_r > lss_pkg::ANGLE_ZERO) && (a_angle_r < lss_pkg::ANGLE_QUARTER);
    ang_fl  = (a_angle_r > lss_pkg::ANGLE_QUARTER) && (a_angle_r < lss_pkg::ANGLE_HALF);
    ang_bl  = (a_angle_r > -lss_pkg::ANGLE_HALF) && (a_angle_r < -lss_pkg::ANGLE_QUARTER);
    ang_br  = (a_angle_r > -lss_pkg::ANGLE_QUARTER) && (a_angle_r < lss_pkg::ANGLE_ZERO);
    ang_fwd = (a_angle_r > lss_pkg::ANGLE_ZERO) && (a_angle_r < lss_pkg::ANGLE_HALF);
    hit_fr  = near_band && ang_fr;
    hit_fl  = near_band && ang_fl;
    hit_bl  = (a_dist_r < radius_r) && ang_bl;
    hit_br  = near_band && ang_br;
    hit_far = !(hit_fr || hit_fl || hit_bl || hit_br) && (far_dist_r < a_dist_r) && ang_fwd;
  end

  // saturating bump of the matching counter
  always_comb begin
    cnt_bump = cnt_r;
    if (hit_fr && (cnt_r.front_right < CNT_CAP))
      cnt_bump.front_right = cnt_r.front_right + 1'b1;
    if (hit_fl && (cnt_r.front_left < CNT_CAP))
      cnt_bump.front_left = cnt_r.front_left + 1'b1;
    if (hit_bl && (cnt_r.back_left < CNT_CAP))
      cnt_bump.back_left = cnt_r.back_left + 1'b1;
    if (hit_br && (cnt_r.back_right < CNT_CAP))
      cnt_bump.back_right = cnt_r.back_right + 1'b1;
    if (hit_far && (cnt_r.far < CNT_CAP))
      cnt_bump.far = cnt_r.far + 1'b1;
  end

  // counters clear once the scan is handed to the snapshot
  always_comb begin
    cnt_nxt = cnt_r;
    if (a_adv) begin
      cnt_nxt = a_last_r ? '0 : cnt_bump;
    end
    b_valid_nxt = (b_valid_r && !b_adv) || (a_adv && a_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_last_r) begin
      b_cnt_r <= cnt_bump;
    end
  end

  // turn command: gain times the left/right imbalance beyond the deadband
  always_comb begin
    turn_left_high = b_cnt_r.front_left > b_cnt_r.front_right;
    abs_diff = turn_left_high ? (b_cnt_r.front_left - b_cnt_r.front_right)
                              : (b_cnt_r.front_right - b_cnt_r.front_left);
    turning  = abs_diff > deadband_r;
    excess   = abs_diff - deadband_r;
    prod     = excess * gain_r;
    prod_sat = (prod > lss_pkg::TURN_LIMIT) ? lss_pkg::TURN_LIMIT : prod;
    if (!turning) begin
      turn_nxt = '0;
    end else if (turn_left_high) begin
      turn_nxt = -$signed(prod_sat);
    end else begin
      turn_nxt = $signed(prod_sat);
    end
  end

  // zone flag latches on few back-left and enough far points
  always_comb begin
    zone_cond = (b_cnt_r.back_left != '0) && (b_cnt_r.back_left < back_limit_r) &&
                (b_cnt_r.far > far_min_r);
    zone_nxt  = zone_r || zone_cond;
    out_valid_nxt = b_adv || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      zone_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (b_adv) begin
        zone_r <= zone_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_cnt_r   <= b_cnt_r;
      out_speed_r <= speed_r;
      out_turn_r  <= turn_nxt;
      out_zone_r  <= zone_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.front_right_count = out_cnt_r.front_right;
  assign out_ch.front_left_count  = out_cnt_r.front_left;
  assign out_ch.back_left_count   = out_cnt_r.back_left;
  assign out_ch.back_right_count  = out_cnt_r.back_right;
  assign out_ch.far_count         = out_cnt_r.far;
  assign out_ch.speed_cmd         = out_speed_r;
  assign out_ch.turn_rate_milli   = out_turn_r;
  assign out_ch.zone              = out_zone_r;

  // counters never pass their cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r.front_right <= CNT_CAP) && (cnt_r.front_left <= CNT_CAP) &&
    (cnt_r.back_left <= CNT_CAP) && (cnt_r.back_right <= CNT_CAP) &&
    (cnt_r.far <= CNT_CAP))
    else $error("sector counter above cap");

  // counters start from zero after a scan closes
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |=> (cnt_r == '0))
    else $error("counters not cleared after last point");

  // zone flag never drops once set
  a_zone_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    zone_r |=> zone_r)
    else $error("zone flag dropped");

  // a snapshot is only overwritten once it has moved on
  a_snap_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |-> (!b_valid_r || b_adv))
    else $error("scan snapshot overwritten");

endmodule

`default_nettype wire
